// ===== hw/rtl/csu_pkg.sv =====
// Shared types and constants of the counting semaphore unit.
// No dependencies; the top level of the unit imports this package.
`default_nettype none

package csu_pkg;

	// Field widths, fixed by the command format.
	localparam int FUNC_W   = 3;
	localparam int SEM_W    = 5;
	localparam int REQ_W    = 5;
	localparam int GRP_W    = 16;
	localparam int CNT_W    = 16;
	localparam int STATUS_W = 3;

	// Table sizes. Slots and requesters are addressed by 5-bit fields.
	localparam int SLOT_CNT       = 1 << SEM_W;
	localparam int REQ_CNT        = 1 << REQ_W;
	localparam int NUM_SEMAPHORES = 32;
	localparam int NUM_REQUESTERS = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_INIT     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DESTROY  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_TRYWAIT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_WAIT     = 3'd3;
	localparam logic [FUNC_W-1:0] FN_POST     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_GETVALUE = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TRY_FAIL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OWNER    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// One entry of the per-semaphore memory.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [GRP_W-1:0] owner;
		logic [REQ_W-1:0] head;
		logic [REQ_W-1:0] tail;
	} csu_sem_t;

	localparam int SEM_ENTRY_W = $bits(csu_sem_t);

endpackage

`default_nettype wire

// ===== hw/rtl/csu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for every memory of the counting semaphore unit.
`default_nettype none

module csu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/counting_semaphore_unit.sv =====
// Top level of the counting semaphore unit: command sequencer, slot bitmaps
// and result register. Depends on csu_pkg and csu_ram.
`default_nettype none

// Channel   Handshake              Payload
// command   start, busy            func, sem_select, requester, caller_group,
//                                  shared, initial_value
// result    done (one-cycle beat)  status, sem_out, value_out, woken_valid,
//                                  woken_requester
//
// A command beat is taken at a rising edge with start high and busy low.
// Most commands first read the semaphore memory and then check, modify and
// write it back. A post that releases a waiter whose queue holds more than
// one entry adds a further step, because the link memory is read at the head
// that the first read returned. The result beat appears in the cycle after
// the write-back, while the unit already takes a new command. Reset clears
// the in-use and queue-nonempty bitmaps at once; the memories need no
// clearing pass. The receiver cannot stall, so done lasts one cycle.

module counting_semaphore_unit
	import csu_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [SEM_W-1:0]    sem_select,
	input  wire logic [REQ_W-1:0]    requester,
	input  wire logic [GRP_W-1:0]    caller_group,
	input  wire logic                shared,
	input  wire logic [CNT_W-1:0]    initial_value,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [SEM_W-1:0]         sem_out,
	output logic [CNT_W-1:0]         value_out,
	output logic                     woken_valid,
	output logic [REQ_W-1:0]         woken_requester
);

	// Sequencer states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_NEXT = 2'd2;

	logic [1:0] state_q, state_d;

	// Captured command.
	logic [FUNC_W-1:0] func_q;
	logic [SEM_W-1:0]  sel_q;
	logic [REQ_W-1:0]  req_q;
	logic [GRP_W-1:0]  grp_q;
	logic              shared_q;
	logic [CNT_W-1:0]  init_q;

	// Slot bitmaps, held in flops so reset clears them at once.
	logic [SLOT_CNT-1:0] in_use_q, in_use_d;
	logic [SLOT_CNT-1:0] qne_q, qne_d;

	// Semaphore memory ports.
	logic                   sem_we, sem_re;
	logic [SEM_W-1:0]       sem_waddr;
	csu_sem_t               sem_wdata, sem_rd;
	logic [SEM_ENTRY_W-1:0] sem_rdata;

	// Waiter link memory ports.
	logic             nw_we, nw_re;
	logic [REQ_W-1:0] nw_waddr, nw_wdata, nw_raddr, nw_rdata;

	// Result computed this cycle.
	logic                res_fire;
	logic [STATUS_W-1:0] res_status;
	logic [SEM_W-1:0]    res_sem;
	logic [CNT_W-1:0]    res_value;
	logic                res_wv;
	logic [REQ_W-1:0]    res_wr;

	logic             accept;
	logic [SEM_W-1:0] free_slot;
	logic             slot_found;
	logic             denied;
	logic             req_ok;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign sem_re = accept;
	assign sem_rd = csu_sem_t'(sem_rdata);

	csu_ram #(
		.WIDTH(SEM_ENTRY_W),
		.DEPTH(SLOT_CNT)
	) u_sem_ram (
		.clk  (clk),
		.we   (sem_we),
		.waddr(sem_waddr),
		.wdata(sem_wdata),
		.re   (sem_re),
		.raddr(sem_select),
		.rdata(sem_rdata)
	);

	csu_ram #(
		.WIDTH(REQ_W),
		.DEPTH(REQ_CNT)
	) u_link_ram (
		.clk  (clk),
		.we   (nw_we),
		.waddr(nw_waddr),
		.wdata(nw_wdata),
		.re   (nw_re),
		.raddr(nw_raddr),
		.rdata(nw_rdata)
	);

	// Lowest free slot among the implemented ones.
	always_comb begin
		free_slot  = '0;
		slot_found = 1'b0;
		for (int i = SLOT_CNT - 1; i >= 0; i--) begin
			if (i < NUM_SEMAPHORES && !in_use_q[i]) begin
				free_slot  = SEM_W'(i);
				slot_found = 1'b1;
			end
		end
	end

	// A slot may be used only while allocated, and a private slot only by
	// the group that created it.
	assign denied = (32'(sel_q) >= NUM_SEMAPHORES) || !in_use_q[sel_q] ||
		(sem_rd.owner != '0 && sem_rd.owner != grp_q);
	assign req_ok = (32'(req_q) < NUM_REQUESTERS);

	always_comb begin
		state_d    = state_q;
		in_use_d   = in_use_q;
		qne_d      = qne_q;
		sem_we     = 1'b0;
		sem_waddr  = sel_q;
		sem_wdata  = sem_rd;
		nw_we      = 1'b0;
		nw_waddr   = sem_rd.tail;
		nw_wdata   = req_q;
		nw_re      = 1'b0;
		nw_raddr   = sem_rd.head;
		res_fire   = 1'b0;
		res_status = ST_OK;
		res_sem    = sel_q;
		res_value  = '0;
		res_wv     = 1'b0;
		res_wr     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d  = S_IDLE;
				res_fire = 1'b1;
				if (func_q > FN_GETVALUE) begin
					// Unknown operation: answer ok and change nothing.
					res_status = ST_OK;
				end else if (func_q == FN_INIT) begin
					if (!slot_found) begin
						res_status = ST_FULL;
						res_sem    = '0;
					end else begin
						in_use_d[free_slot] = 1'b1;
						qne_d[free_slot]    = 1'b0;
						sem_we              = 1'b1;
						sem_waddr           = free_slot;
						sem_wdata.count     = init_q;
						sem_wdata.owner     = shared_q ? '0 : grp_q;
						res_sem             = free_slot;
						res_value           = init_q;
					end
				end else if (denied) begin
					res_status = ST_OWNER;
				end else begin
					case (func_q)
						FN_DESTROY: begin
							in_use_d[sel_q] = 1'b0;
							qne_d[sel_q]    = 1'b0;
						end
						FN_TRYWAIT, FN_WAIT: begin
							if (sem_rd.count != '0) begin
								sem_we          = 1'b1;
								sem_wdata.count = sem_rd.count - 1'b1;
								res_value       = sem_rd.count - 1'b1;
							end else if (func_q == FN_TRYWAIT || !req_ok) begin
								res_status = ST_TRY_FAIL;
							end else begin
								// Append the caller behind the current tail.
								if (qne_q[sel_q]) begin
									nw_we = 1'b1;
								end else begin
									sem_wdata.head = req_q;
									qne_d[sel_q]   = 1'b1;
								end
								sem_we         = 1'b1;
								sem_wdata.tail = req_q;
								res_status     = ST_BLOCKED;
							end
						end
						FN_POST: begin
							if (qne_q[sel_q]) begin
								res_value = sem_rd.count;
								res_wv    = 1'b1;
								res_wr    = sem_rd.head;
								if (sem_rd.head == sem_rd.tail) begin
									qne_d[sel_q] = 1'b0;
								end else if (32'(sem_rd.head) < NUM_REQUESTERS) begin
									// Fetch the next waiter before writing the head.
									nw_re    = 1'b1;
									res_fire = 1'b0;
									state_d  = S_NEXT;
								end
							end else begin
								sem_we = 1'b1;
								if (sem_rd.count != COUNT_MAX) begin
									sem_wdata.count = sem_rd.count + 1'b1;
									res_value       = sem_rd.count + 1'b1;
								end else begin
									res_value = sem_rd.count;
								end
							end
						end
						default: begin
							res_value = sem_rd.count;
						end
					endcase
				end
			end
			S_NEXT: begin
				// The link read has returned the new head of the queue.
				state_d        = S_IDLE;
				sem_we         = 1'b1;
				sem_wdata.head = nw_rdata;
				res_fire       = 1'b1;
				res_value      = sem_rd.count;
				res_wv         = 1'b1;
				res_wr         = sem_rd.head;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_use_q <= '0;
			qne_q    <= '0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			in_use_q <= in_use_d;
			qne_q    <= qne_d;
			done     <= res_fire;
		end
	end

	// Command capture and result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			sel_q    <= sem_select;
			req_q    <= requester;
			grp_q    <= caller_group;
			shared_q <= shared;
			init_q   <= initial_value;
		end
		if (res_fire) begin
			status          <= res_status;
			sem_out         <= res_sem;
			value_out       <= res_value;
			woken_valid     <= res_wv;
			woken_requester <= res_wr;
		end
	end

`ifndef ASSERT_OFF
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_EXEC || $past(state_q) == S_NEXT))
		else $error("result beat without a finishing command");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted command did not enter execution");

	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && woken_valid) |-> (status == ST_OK))
		else $error("waiter released with a failing status");

	a_queue_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		((qne_q & ~in_use_q) == '0))
		else $error("nonempty queue on a free slot");

	a_next_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NEXT) |-> ($past(state_q) == S_EXEC && $past(func_q) == FN_POST))
		else $error("link fetch outside a post");
`endif

endmodule

`default_nettype wire
